// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the LRU cache RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHECK_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Property whose consequence must follow its condition, checked with the non-overlapping implication.
`define CHECK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizes, codes, item and control types.
// No dependencies; used by every module of the cache.
`timescale 1ns / 1ps

package lkvc_pkg;

	// Number of cells in the recency chain.
	localparam int MaxEntries = 16;
	localparam int CountW     = $clog2(MaxEntries + 1);
	localparam int KeyW       = 32;
	localparam int ValW       = 32;

	// Operation codes carried in the func field.
	localparam logic FuncGet = 1'b0;
	localparam logic FuncPut = 1'b1;

	// Value returned by a get that misses.
	localparam logic signed [ValW-1:0] MissValue = -32'sd1;

	// Reset value of the capacity register.
	localparam logic [CountW-1:0] CapacityReset = CountW'(MaxEntries);

	// Configuration register indexes.
	localparam logic RegCapacity = 1'b0;

	// One input item.
	typedef struct packed {
		logic                   func;
		logic signed [KeyW-1:0] key;
		logic signed [ValW-1:0] value;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic                   found;
		logic signed [ValW-1:0] read_value;
	} out_item_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// Control sent from the controller to one cell.
	typedef struct packed {
		logic capture;  // register the key compare result
		logic load;     // take the neighbor's entry
	} cell_ctl_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
// One cell of the recency chain: holds a key and a value, compares the key.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_cell
	import lkvc_pkg::*;
(
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic signed [KeyW-1:0] cmp_key,
	input  logic signed [KeyW-1:0] prev_key,
	input  logic signed [ValW-1:0] prev_value,
	output logic signed [KeyW-1:0] slot_key,
	output logic signed [ValW-1:0] slot_value,
	output logic                   match
);

	logic signed [KeyW-1:0] key_q;
	logic signed [ValW-1:0] value_q;
	logic                   match_q;

	// The entry moves one place down the chain when loaded.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	// The compare against the broadcast key is held for the update cycle.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_q <= (key_q == cmp_key);
		end
	end

	assign slot_key   = key_q;
	assign slot_value = value_q;
	assign match      = match_q;

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// An accepted item's compare flags are registered, the update state shifts the chain, and the result is registered.
// No new item is taken while busy: each item compares in the cell row, then shifts, before the next is accepted.
// The result strobe is one cycle wide, as the receiver cannot stall.
// Reset clears the controller, the entry count and sets capacity to 16.
// Slot contents are not cleared; only slots below the entry count are read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_key_value_cache_core
	import lkvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    request,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t                 state_q;
	state_t                 state_next;
	logic                   accept;
	in_item_t               op_q;
	logic [CountW-1:0]      count_q;
	logic [CountW-1:0]      cap_q;
	logic [CountW-1:0]      cap_eff;
	logic                   done_q;
	out_item_t              result_q;
	logic                   updating;

	cell_ctl_t              cell_ctl   [MaxEntries];
	logic signed [KeyW-1:0] slot_key_w [MaxEntries];
	logic signed [ValW-1:0] slot_val_w [MaxEntries];
	logic [MaxEntries-1:0]  match_w;
	logic [MaxEntries-1:0]  valid_match;
	logic [MaxEntries-1:0]  first_hit;
	logic [MaxEntries-1:0]  none_before;
	logic                   hit;
	logic signed [ValW-1:0] hit_value;
	logic signed [KeyW-1:0] head_key;
	logic signed [ValW-1:0] head_value;
	logic                   is_put;

	// Configuration port: one register, writes complete in the access cycle.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegCapacity) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapacityReset;
		end else if (psel && penable && pwrite && (paddr[2] == RegCapacity)) begin
			cap_q <= pwdata[CountW-1:0];
		end
	end

	assign cap_eff = (cap_q > CountW'(MaxEntries)) ? CountW'(MaxEntries) : cap_q;

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_next = state_q;
		busy       = 1'b0;
		accept     = 1'b0;
		updating   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				accept = start;
				if (start) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				busy       = 1'b1;
				updating   = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// The accepted item is held for the update cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= request;
		end
	end

	// Lowest valid matching slot, and whether no match lies below each slot.
	always_comb begin
		for (int i = 0; i < MaxEntries; i++) begin
			valid_match[i] = match_w[i] && (CountW'(i) < count_q);
		end
		for (int i = 0; i < MaxEntries; i++) begin
			none_before[i] = ~|(valid_match & ((MaxEntries'(1) << i) - MaxEntries'(1)));
			first_hit[i]   = valid_match[i] && none_before[i];
		end
	end

	assign hit    = |valid_match;
	assign is_put = (op_q.func == FuncPut);

	// Value of the hit slot, picked by the one-hot first match.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < MaxEntries; i++) begin
			hit_value = hit_value | (slot_val_w[i] & {ValW{first_hit[i]}});
		end
	end

	assign head_key   = op_q.key;
	assign head_value = is_put ? op_q.value : hit_value;

	// Per-cell control: compare on accept, shift on update.
	always_comb begin
		for (int i = 0; i < MaxEntries; i++) begin
			cell_ctl[i].capture = accept;
			if (i == 0) begin
				cell_ctl[i].load = updating && (hit || is_put);
			end else if (hit) begin
				cell_ctl[i].load = updating && none_before[i];
			end else begin
				cell_ctl[i].load = updating && is_put && (CountW'(i) <= count_q);
			end
		end
	end

	// Row of cells; each takes its upper neighbor's entry on a shift.
	for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
		if (g == 0) begin : g_head
			lkvc_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[g]),
				.cmp_key    (request.key),
				.prev_key   (head_key),
				.prev_value (head_value),
				.slot_key   (slot_key_w[g]),
				.slot_value (slot_val_w[g]),
				.match      (match_w[g])
			);
		end else begin : g_body
			lkvc_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[g]),
				.cmp_key    (request.key),
				.prev_key   (slot_key_w[g-1]),
				.prev_value (slot_val_w[g-1]),
				.slot_key   (slot_key_w[g]),
				.slot_value (slot_val_w[g]),
				.match      (match_w[g])
			);
		end
	end

	// Entry count grows on a put that misses, limited by the capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (updating && is_put && !hit) begin
			if ((count_q + CountW'(1)) > cap_eff) begin
				count_q <= cap_eff;
			end else begin
				count_q <= count_q + CountW'(1);
			end
		end
	end

	// Result strobe for a get item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= updating && !is_put;
		end
	end

	always_ff @(posedge clk) begin
		if (updating) begin
			result_q.found      <= hit;
			result_q.read_value <= hit ? hit_value : MissValue;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The compare flags are only meaningful in the update cycle that follows their capture.
	`CHECK_NEXT(a_accept_busy, accept, busy, "accepted item did not enter the update cycle")
	`CHECK_ALWAYS(a_first_onehot, !updating || $onehot0(first_hit), "more than one first-match slot")
	`CHECK_ALWAYS(a_count_range, count_q <= CountW'(MaxEntries), "entry count beyond the chain")
	`CHECK_NEXT(a_get_result, updating && !is_put, done, "get item gave no result strobe")

endmodule

// ===== tb/sv/lru_key_value_cache_core_tb.sv =====
// Self-checking testbench for the LRU key-value cache core.
// Drives get and put items plus APB capacity writes and checks every lookup result.
// Depends on lkvc_pkg and lru_key_value_cache_core.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
	import lkvc_pkg::*;

	// Mirror of the cache contents that predicts every lookup result.
	class cache_scoreboard;
		logic [KeyW-1:0]   slot_keys [MaxEntries];
		logic [ValW-1:0]   slot_vals [MaxEntries];
		int unsigned       entries;
		logic [CountW-1:0] capacity;
		out_item_t         expected_reads [$];
		int                failures;
		int                requests;
		int                lookups;
		int                hits;

		function new();
			entries  = 0;
			capacity = CapacityReset;
			failures = 0;
			requests = 0;
			lookups  = 0;
			hits     = 0;
		endfunction

		// Move slots 0..depth-1 down by one and place the entry at the front.
		function void move_to_front(int unsigned depth, logic [KeyW-1:0] k,
				logic [ValW-1:0] v);
			int unsigned i;
			if (depth > MaxEntries - 1) begin
				depth = MaxEntries - 1;
			end
			for (i = depth; i > 0; i--) begin
				slot_keys[i] = slot_keys[i-1];
				slot_vals[i] = slot_vals[i-1];
			end
			slot_keys[0] = k;
			slot_vals[0] = v;
		endfunction

		// Apply one accepted item and queue the lookup result it produces.
		function void note_request(in_item_t req);
			int unsigned     n;
			int unsigned     at;
			int unsigned     limit;
			bit              hit;
			logic [ValW-1:0] stored;
			out_item_t       rsp;
			requests++;
			n   = (entries > MaxEntries) ? MaxEntries : entries;
			hit = 1'b0;
			at  = 0;
			for (int unsigned i = 0; i < n; i++) begin
				if (!hit && slot_keys[i] == req.key) begin
					hit = 1'b1;
					at  = i;
				end
			end
			if (hit) begin
				stored = (req.func == FuncPut) ? req.value : slot_vals[at];
				move_to_front(at, req.key, stored);
				if (req.func == FuncGet) begin
					rsp.found      = 1'b1;
					rsp.read_value = stored;
					expected_reads.push_back(rsp);
				end
			end else if (req.func == FuncGet) begin
				rsp.found      = 1'b0;
				rsp.read_value = MissValue;
				expected_reads.push_back(rsp);
			end else begin
				// A miss on put inserts at the front and trims to the capacity.
				limit = (capacity > MaxEntries) ? MaxEntries : capacity;
				move_to_front(n, req.key, req.value);
				entries = (n + 1 > limit) ? limit : n + 1;
			end
		endfunction

		// Compare one strobed result with the oldest predicted lookup.
		function void check_read(out_item_t got);
			out_item_t want;
			if (expected_reads.size() == 0) begin
				$display("%0t: result with none expected: found %0b read_value %0d",
					$time, got.found, got.read_value);
				failures++;
				return;
			end
			want = expected_reads.pop_front();
			lookups++;
			if (want.found) begin
				hits++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found mismatch: expected %0b actual %0b",
					$time, want.found, got.found);
				failures++;
			end
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value mismatch: expected %0d actual %0d",
					$time, want.read_value, got.read_value);
				failures++;
			end
		endfunction

		function int pending();
			return expected_reads.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    request;
	logic        done;
	out_item_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cache_scoreboard sb;
	bit              no_gaps;
	int              settings_done;

	lru_key_value_cache_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running 50 MHz clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("lru_key_value_cache_core regression: fail");
		$finish;
	end

	// Observe accepted items and strobed results at each rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_request(request);
			end
			if (done) begin
				sb.check_read(result);
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_request(input logic func, input logic [31:0] key,
			input logic [31:0] value);
		in_item_t req;
		int       gap;
		req.func  = func;
		req.key   = key;
		req.value = value;
		start   <= 1'b1;
		request <= req;
		do begin
			@(posedge clk);
		end while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending until every lookup has come back and the last put has settled.
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	// Write the capacity register over APB, then read it back.
	task automatic write_capacity(input logic [CountW-1:0] cap);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {RegCapacity, 2'b00};
		pwdata  <= 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		sb.capacity = cap;
		settings_done++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (prdata !== 32'(cap)) begin
			$display("%0t: capacity readback mismatch: expected %0d actual %0d",
				$time, cap, prdata);
			sb.failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Capacity for each random phase; covers zero, one, the maximum and saturation.
	logic [CountW-1:0] phase_caps [13] = '{16, 1, 0, 31, 4, 17, 16, 2, 8, 20, 3, 12, 16};

	initial begin
		logic [31:0] pool [24];
		int          pool_size;
		logic [31:0] key;
		logic [31:0] value;

		sb            = new();
		no_gaps       = 1'b0;
		settings_done = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		request <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme keys and values, hits, misses and updates at reset capacity.
		send_request(FuncGet, 32'h0000_0000, 32'h0);
		send_request(FuncPut, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(FuncGet, 32'h8000_0000, 32'h0);
		send_request(FuncPut, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(FuncPut, 32'h0000_0000, MissValue);
		send_request(FuncGet, 32'h0000_0000, 32'h0);
		send_request(FuncGet, 32'h7FFF_FFFF, 32'h0);
		send_request(FuncPut, 32'h8000_0000, 32'h0);
		send_request(FuncGet, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(FuncGet, 32'hFFFF_FFFF, 32'h0);
		send_request(FuncGet, 32'h0000_3039, 32'h0);

		// Directed: capacity lowered below the entry count, then eviction order.
		wait_idle();
		write_capacity(2);
		send_request(FuncPut, 32'h0000_0011, 32'h0000_0111);
		send_request(FuncGet, 32'h7FFF_FFFF, 32'h0);
		send_request(FuncGet, 32'h0000_0000, 32'h0);
		send_request(FuncPut, 32'h0000_0022, 32'h0000_0222);
		send_request(FuncGet, 32'h0000_0011, 32'h0);
		send_request(FuncGet, 32'h0000_0022, 32'h0);

		// Directed: zero capacity stores nothing new but still updates on a hit.
		wait_idle();
		write_capacity(0);
		send_request(FuncPut, 32'h0000_0022, 32'h5555_AAAA);
		send_request(FuncGet, 32'h0000_0022, 32'h0);
		send_request(FuncPut, 32'h0000_0033, 32'h0000_0333);
		send_request(FuncGet, 32'h0000_0033, 32'h0);
		send_request(FuncGet, 32'h0000_0011, 32'h0);

		// Random phases: keys mostly drawn from a small pool so hits and evictions are common.
		for (int p = 0; p < 13; p++) begin
			wait_idle();
			write_capacity(phase_caps[p]);
			no_gaps   = ($urandom_range(0, 3) == 0);
			pool_size = $urandom_range(2, 24);
			for (int i = 0; i < pool_size; i++) begin
				if (i == 0) begin
					pool[i] = 32'h8000_0000;
				end else if (i == 1) begin
					pool[i] = 32'h7FFF_FFFF;
				end else if ($urandom_range(0, 3) == 0) begin
					pool[i] = $urandom_range(0, 31);
				end else begin
					pool[i] = $urandom;
				end
			end
			for (int n = 0; n < 100; n++) begin
				if (n == 50 && $urandom_range(0, 2) == 0) begin
					wait_idle();
				end
				key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
					: $urandom;
				value = ($urandom_range(0, 15) == 0) ? MissValue : $urandom;
				send_request($urandom_range(0, 1) ? FuncPut : FuncGet, key, value);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Sent %0d items over %0d capacity settings; checked %0d lookups, %0d hits.",
			sb.requests, settings_done, sb.lookups, sb.hits);
		if (sb.failures == 0) begin
			$display("lru_key_value_cache_core regression: pass");
		end else begin
			$display("lru_key_value_cache_core regression: fail");
		end
		$finish;
	end

endmodule
